### rtl/sprite_table_dma_engine_assert.svh
// Assertion macros shared by the sprite-table DMA engine RTL.
`ifndef SPRITE_TABLE_DMA_ENGINE_ASSERT_SVH
`define SPRITE_TABLE_DMA_ENGINE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define STDMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stdma same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define STDMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stdma next-cycle check failed");

`endif

### rtl/stdma_pkg.sv
// Types and constants of the sprite-table DMA engine.
package stdma_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELAY_W  = 3;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [BYTE_W-1:0] HIGH_PAGE_MASK = 8'hDF;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PREP  = 2'd1,
    PH_FLUSH = 2'd2
  } stdma_phase_t;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } stdma_func_t;

  typedef struct packed {
    stdma_func_t        func;
    logic [BYTE_W-1:0]  value;
    logic               hdma_blocking;
    logic [BYTE_W-1:0]  read_data;
  } stdma_in_t;

  typedef struct packed {
    logic               read_req;
    logic [ADDR_W-1:0]  read_addr;
    logic               oam_req;
    logic [ADDR_W-1:0]  oam_addr;
    logic               write_valid;
    logic [BYTE_W-1:0]  write_data;
    logic               bus_acquire;
    logic               bus_release;
    logic               busy_res;
  } stdma_out_t;

endpackage

### rtl/stdma_core.sv
// Transfer state and per-request step logic of the sprite-table DMA engine.
`include "sprite_table_dma_engine_assert.svh"

module stdma_core #(
  parameter int unsigned TABLE_BYTES = 160,
  parameter int unsigned TABLE_BASE  = 65024,
  parameter int unsigned START_TICKS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  stdma_pkg::stdma_in_t  item,
  output stdma_pkg::stdma_out_t result
);
  import stdma_pkg::*;

  localparam logic [BYTE_W-1:0]  TABLE_LEN   = BYTE_W'(TABLE_BYTES);
  localparam logic [ADDR_W-1:0]  BASE_ADDR   = ADDR_W'(TABLE_BASE);
  localparam logic [DELAY_W-1:0] DELAY_INIT  = DELAY_W'(START_TICKS);

  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [BYTE_W-1:0]  pend_r, pend_nxt;
  stdma_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0]  src_r, src_nxt;
  logic [BYTE_W-1:0]  cur_r, cur_nxt;

  stdma_phase_t       ph_now;
  logic [BYTE_W-1:0]  src_now;
  logic [BYTE_W-1:0]  cur_now;

  always_comb begin
    delay_nxt = delay_r;
    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    src_nxt   = src_r;
    cur_nxt   = cur_r;
    ph_now    = phase_r;
    src_now   = src_r;
    cur_now   = cur_r;
    result    = '0;
    if (item.func == FUNC_START) begin
      pend_nxt  = (item.value[7:5] == 3'b111) ? (item.value & HIGH_PAGE_MASK) : item.value;
      delay_nxt = DELAY_INIT;
    end else begin
      if (delay_r != '0) begin
        delay_nxt = delay_r - DELAY_W'(1);
        if (delay_r == DELAY_W'(1)) begin
          result.bus_acquire = 1'b1;
          ph_now  = PH_PREP;
          src_now = pend_r;
          cur_now = '0;
        end
      end
      src_nxt = src_now;
      cur_nxt = cur_now;
      unique case (ph_now)
        PH_PREP: begin
          if (cur_now < TABLE_LEN) begin
            if (!item.hdma_blocking) begin
              result.read_req  = 1'b1;
              result.read_addr = {src_now, cur_now};
              result.oam_req   = 1'b1;
              result.oam_addr  = BASE_ADDR + {{(ADDR_W-BYTE_W){1'b0}}, cur_now};
            end
            phase_nxt = PH_FLUSH;
          end else begin
            result.bus_release = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_FLUSH: begin
          if (!item.hdma_blocking) begin
            result.write_valid = 1'b1;
            result.write_data  = item.read_data;
          end
          cur_nxt   = cur_now + BYTE_W'(1);
          phase_nxt = PH_PREP;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    result.busy_res = (phase_nxt == PH_PREP) || (phase_nxt == PH_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      pend_r  <= '0;
      phase_r <= PH_IDLE;
      src_r   <= '0;
      cur_r   <= '0;
    end else if (step_en) begin
      delay_r <= delay_nxt;
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
      src_r   <= src_nxt;
      cur_r   <= cur_nxt;
    end
  end

  `STDMA_ASSERT_NOW(a_cursor_bound, 1'b1, cur_r <= TABLE_LEN)
  `STDMA_ASSERT_NEXT(a_acquire_prep, step_en && result.bus_acquire,
                     (phase_r == PH_FLUSH || phase_r == PH_IDLE) && cur_r == '0)
  `STDMA_ASSERT_NEXT(a_release_idle, step_en && result.bus_release, phase_r == PH_IDLE)
  `STDMA_ASSERT_NEXT(a_start_holds, step_en && item.func == FUNC_START,
                     $stable(phase_r) && $stable(cur_r) && delay_r == DELAY_INIT)

endmodule

### rtl/sprite_table_dma_engine.sv
// Top level of the sprite-table DMA engine: request and result registers around the step core.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata, in_tuser (func)
//  out_    | out | out_tvalid/out_tready | out_tdata
//
//  One request per cycle sustained while out_tready is high; results pass both registers.
//  The step logic is one pass from the request register into the result register.
//  rst_n is synchronous, active low, and idles both registers and the transfer state.
//  A stalled result holds the request register; a new request is taken as the result leaves.
`include "sprite_table_dma_engine_assert.svh"

module sprite_table_dma_engine #(
  parameter int unsigned TABLE_BYTES = 160,
  parameter int unsigned TABLE_BASE  = 65024,
  parameter int unsigned START_TICKS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] value, [8] hdma_blocking, [16:9] read_data, [23:17] zero
  input  logic [stdma_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] func
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] read_req, [16:1] read_addr, [17] oam_req, [33:18] oam_addr, [34] write_valid,
  // [42:35] write_data, [43] bus_acquire, [44] bus_release, [45] busy_res, [47:46] zero
  output logic [stdma_pkg::OUT_DATA_W-1:0] out_tdata
);
  import stdma_pkg::*;

  logic       in_valid_r;
  stdma_in_t  in_item_r;
  logic       out_valid_r;
  stdma_out_t out_item_r;
  stdma_out_t step_res;
  logic       advance;
  logic       in_take;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  stdma_core #(
    .TABLE_BYTES (TABLE_BYTES),
    .TABLE_BASE  (TABLE_BASE),
    .START_TICKS (START_TICKS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.func          <= stdma_func_t'(in_tuser[0]);
      in_item_r.value         <= in_tdata[7:0];
      in_item_r.hdma_blocking <= in_tdata[8];
      in_item_r.read_data     <= in_tdata[16:9];
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_item_r.busy_res,
                       out_item_r.bus_release,
                       out_item_r.bus_acquire,
                       out_item_r.write_data,
                       out_item_r.write_valid,
                       out_item_r.oam_addr,
                       out_item_r.oam_req,
                       out_item_r.read_addr,
                       out_item_r.read_req};

  `STDMA_ASSERT_NEXT(a_stall_keeps_request, in_valid_r && !advance, in_valid_r)
  `STDMA_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  `STDMA_ASSERT_NOW(a_no_overwrite, advance && out_valid_r, out_tready)

endmodule

### dv/testbench.sv
// Self-checking testbench for the sprite-table DMA engine: directed table, then random transfers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stdma_pkg::*;

  localparam int unsigned TABLE_BYTES = 160;
  localparam int unsigned TABLE_BASE  = 65024;
  localparam int unsigned START_TICKS = 4;
  localparam int unsigned ITEMS       = 600;
  localparam int unsigned QUIET_AFTER = 500;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    stdma_func_t       func;
    logic [BYTE_W-1:0] value;
    logic              blocked;
    logic [BYTE_W-1:0] rdata;
    bit                typed;
    stdma_out_t        res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // predictor copy of the engine state
  logic [DELAY_W-1:0] countdown;
  logic [BYTE_W-1:0]  armed_page;
  logic [BYTE_W-1:0]  src_page;
  logic [BYTE_W-1:0]  cursor;
  stdma_phase_t       xfer_phase;

  stdma_out_t  dma_result_q[$];
  stim_row_t   dir_table[$];
  int unsigned sent_count = 0;
  int unsigned blocked_ticks = 0;
  int unsigned acquires = 0;
  int unsigned releases = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  sprite_table_dma_engine #(
    .TABLE_BYTES(TABLE_BYTES),
    .TABLE_BASE (TABLE_BASE),
    .START_TICKS(START_TICKS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               dma_result_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic stdma_out_t mk_result(logic rr, logic [15:0] ra, logic orq, logic [15:0] oa,
                                           logic wv, logic [7:0] wd, logic acq, logic rel,
                                           logic busy);
    stdma_out_t r;
    r.read_req    = rr;
    r.read_addr   = ra;
    r.oam_req     = orq;
    r.oam_addr    = oa;
    r.write_valid = wv;
    r.write_data  = wd;
    r.bus_acquire = acq;
    r.bus_release = rel;
    r.busy_res    = busy;
    return r;
  endfunction

  function automatic stdma_out_t dma_tick_step(stdma_in_t rq);
    stdma_out_t        r;
    logic [BYTE_W-1:0] pg;
    r = '0;
    if (rq.func == FUNC_START) begin
      pg = rq.value;
      if (pg >= 8'hE0) pg = pg & HIGH_PAGE_MASK;
      armed_page = pg;
      countdown  = DELAY_W'(START_TICKS);
    end else begin
      if (countdown != '0) begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          r.bus_acquire = 1'b1;
          xfer_phase    = PH_PREP;
          src_page      = armed_page;
          cursor        = '0;
        end
      end
      case (xfer_phase)
        PH_PREP: begin
          if (cursor < TABLE_BYTES) begin
            if (!rq.hdma_blocking) begin
              r.read_req  = 1'b1;
              r.read_addr = {src_page, 8'h00} + {8'h00, cursor};
              r.oam_req   = 1'b1;
              r.oam_addr  = ADDR_W'(TABLE_BASE) + {8'h00, cursor};
            end
            xfer_phase = PH_FLUSH;
          end else begin
            r.bus_release = 1'b1;
            xfer_phase    = PH_IDLE;
          end
        end
        PH_FLUSH: begin
          if (!rq.hdma_blocking) begin
            r.write_valid = 1'b1;
            r.write_data  = rq.read_data;
          end
          cursor     = cursor + 1'b1;
          xfer_phase = PH_PREP;
        end
        default: begin
          xfer_phase = PH_IDLE;
        end
      endcase
    end
    r.busy_res = (xfer_phase == PH_PREP) || (xfer_phase == PH_FLUSH);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_row(stdma_func_t f, logic [7:0] v, logic b, logic [7:0] d,
                                   bit typed, stdma_out_t res);
    stim_row_t row;
    row.func    = f;
    row.value   = v;
    row.blocked = b;
    row.rdata   = d;
    row.typed   = typed;
    row.res     = res;
    dir_table.push_back(row);
  endfunction

  // Drive one request; the expectation is queued at the edge that accepts it.
  task automatic send_req(stdma_func_t f, logic [7:0] v, logic b, logic [7:0] d, bit typed,
                          stdma_out_t typed_res);
    stdma_in_t   rq;
    stdma_out_t  pred;
    int unsigned gap;
    if (sent_count < QUIET_AFTER && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, d, b, v};
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    rq.func          = f;
    rq.value         = v;
    rq.hdma_blocking = b;
    rq.read_data     = d;
    pred = dma_tick_step(rq);
    dma_result_q.push_back(typed ? typed_res : pred);
    sent_count++;
    if (f == FUNC_TICK && b) blocked_ticks++;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sent_count < QUIET_AFTER && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stdma_out_t want;
    stdma_out_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_req    = out_tdata[0];
      got.read_addr   = out_tdata[16:1];
      got.oam_req     = out_tdata[17];
      got.oam_addr    = out_tdata[33:18];
      got.write_valid = out_tdata[34];
      got.write_data  = out_tdata[42:35];
      got.bus_acquire = out_tdata[43];
      got.bus_release = out_tdata[44];
      got.busy_res    = out_tdata[45];
      if (dma_result_q.size() == 0) begin
        $error("result 0x%0h with no request outstanding", out_tdata);
        fail_count++;
      end else begin
        want = dma_result_q.pop_front();
        check_field("read_req", want.read_req, got.read_req);
        check_field("read_addr", want.read_addr, got.read_addr);
        check_field("oam_req", want.oam_req, got.oam_req);
        check_field("oam_addr", want.oam_addr, got.oam_addr);
        check_field("write_valid", want.write_valid, got.write_valid);
        check_field("write_data", want.write_data, got.write_data);
        check_field("bus_acquire", want.bus_acquire, got.bus_acquire);
        check_field("bus_release", want.bus_release, got.bus_release);
        check_field("busy_res", want.busy_res, got.busy_res);
      end
      if (got.bus_acquire) acquires++;
      if (got.bus_release) releases++;
    end
  end

  initial begin
    stdma_out_t  idle_res;
    stdma_out_t  none;
    logic [7:0]  page;
    int unsigned n_ticks;
    int unsigned restart_at;
    bit          first;

    countdown  = '0;
    armed_page = '0;
    src_page   = '0;
    cursor     = '0;
    xfer_phase = PH_IDLE;
    idle_res   = '0;
    none       = '0;

    // ticks straight out of reset, then high-page starts and a restart
    push_row(FUNC_TICK,  8'hFF, 1'b1, 8'hFF, 1, idle_res);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h00, 1, idle_res);
    push_row(FUNC_START, 8'hFF, 1'b1, 8'hFF, 1, idle_res);
    push_row(FUNC_START, 8'hE0, 1'b0, 8'h00, 1, idle_res);
    push_row(FUNC_TICK,  8'h5A, 1'b0, 8'hA5, 1, idle_res);
    push_row(FUNC_TICK,  8'hFF, 1'b1, 8'h00, 1, idle_res);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'hFF, 1, idle_res);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h00, 1,
             mk_result(1'b1, 16'hC000, 1'b1, 16'hFE00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'hFF, 1,
             mk_result(1'b0, 16'h0, 1'b0, 16'h0, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b1));
    // blocked prepare and flush: only busy survives
    push_row(FUNC_TICK,  8'h00, 1'b1, 8'h00, 1,
             mk_result(1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    push_row(FUNC_TICK,  8'h00, 1'b1, 8'hAA, 1,
             mk_result(1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    push_row(FUNC_TICK,  8'h12, 1'b0, 8'h34, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h00, 0, none);
    // start while a transfer runs
    push_row(FUNC_START, 8'hDF, 1'b0, 8'h00, 1,
             mk_result(1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h11, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h22, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h33, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h44, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h55, 0, none);
    push_row(FUNC_START, 8'hFE, 1'b1, 8'h00, 0, none);
    push_row(FUNC_TICK,  8'hFF, 1'b0, 8'h66, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h77, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b1, 8'h88, 0, none);
    push_row(FUNC_TICK,  8'h00, 1'b0, 8'h99, 0, none);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_req(dir_table[i].func, dir_table[i].value, dir_table[i].blocked,
               dir_table[i].rdata, dir_table[i].typed, dir_table[i].res);
    end

    first = 1;
    while (sent_count < ITEMS) begin
      if (first || $urandom_range(0, 9) < 7) begin
        // full transfer with random content, sometimes restarted midway
        first = 0;
        page = $urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom);
        send_req(FUNC_START, page, 1'($urandom), 8'($urandom), 0, none);
        n_ticks    = START_TICKS + 2 * TABLE_BYTES + $urandom_range(1, 4);
        restart_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n_ticks - 1) : 0;
        for (int unsigned i = 0; i < n_ticks; i++) begin
          if (restart_at != 0 && i == restart_at) begin
            send_req(FUNC_START, 8'($urandom), 1'($urandom), 8'($urandom), 0, none);
          end
          send_req(FUNC_TICK, 8'($urandom), $urandom_range(0, 9) == 0, 8'($urandom), 0, none);
        end
      end else begin
        repeat (12) begin
          send_req(stdma_func_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom),
                   8'($urandom), 0, none);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (dma_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d blocked ticks); saw %0d bus acquires and %0d releases",
             sent_count, blocked_ticks, acquires, releases);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
